[hw/rtl/nqse_pkg.sv]
// ----------------------------------------------------------------------------
// nqse_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nqse_pkg;

    localparam int MAX_BOARD   = 16;
    localparam int ROW_W       = $clog2(MAX_BOARD);
    localparam int COL_W       = 4;
    localparam int DEPTH_W     = $clog2(MAX_BOARD + 1);
    localparam int SIZE_W      = 5;
    localparam int COUNT_W     = 24;
    localparam int QCOLS_W     = 64;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = ((COUNT_W + QCOLS_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0]  BOARD_RESET = SIZE_W'(8);
    localparam logic [DEPTH_W-1:0] MAX_N       = DEPTH_W'(MAX_BOARD);

    typedef struct packed {
        logic clear;
        logic resume;
        logic step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic exhausted;
        logic full;
        logic hit;
        logic fail;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_DONE   = 4'b1000
    } ctrl_state_t;

endpackage

[hw/rtl/n_queens_solution_enumerator_top.sv]
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator_top
// n-queens enumerator: each request returns the next backtracking solution
// ----------------------------------------------------------------------------
//  channel  | dir | signals                         | contents
//  s        | in  | s_tvalid s_tready s_tdata[7:0]  | restart
//  m        | out | m_tvalid m_tready m_tdata[87:0] | solution_number, queen_columns
//           |     | m_tuser                         | found
//  cfg      | in  | cfg_wr_en cfg_wr_data[4:0]      | board_size
//
//  an item runs the start, search and done steps, searching on from the last
//  solution; one try per cycle, all earlier rows checked in parallel lanes
//  the next item is taken once the result is in the output register
//  no clearing pass after reset; board size resets to 8
//  a stalled output holds the result while the next item is accepted
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module n_queens_solution_enumerator_top
    import nqse_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // restart
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // solution_number, queen_columns
    output logic                   m_tuser,   // found
    input  logic                   cfg_wr_en,
    input  logic [SIZE_W-1:0]      cfg_wr_data
);

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [COUNT_W-1:0] out_count;
    logic [QCOLS_W-1:0] out_cols;

    nqse_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .restart  (s_tdata[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nqse_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_found   (m_tuser),
        .out_count   (out_count),
        .out_cols    (out_cols)
    );

    assign m_tdata = OUT_TDATA_W'({out_cols, out_count});

endmodule

[hw/rtl/nqse_ctrl.sv]
// ----------------------------------------------------------------------------
// nqse_ctrl
// request sequencer: accepts an item, runs the search steps, hands off result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nqse_ctrl
    import nqse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     restart,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.clear  = restart;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (stat.exhausted)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.resume = stat.full;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (stat.hit || stat.fail)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_step_only_searching: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (state_reg == ST_SEARCH))
        else $error("search step outside search state");

    a_hit_goes_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.hit) |=> (state_reg == ST_DONE))
        else $error("solution not followed by result handoff");

    a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> s_tready)
        else $error("not ready after result load");

endmodule

[hw/rtl/nqse_dp.sv]
// ----------------------------------------------------------------------------
// nqse_dp
// search datapath: placements, per-row safety lanes, count, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nqse_dp
    import nqse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [SIZE_W-1:0]   cfg_wr_data,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic                out_found,
    output logic [COUNT_W-1:0]  out_count,
    output logic [QCOLS_W-1:0]  out_cols
);

    logic [SIZE_W-1:0]  size_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] cur_reg, cur_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               exh_reg, exh_next;
    logic [COL_W-1:0]   cols_reg [MAX_BOARD];
    logic               valid_reg, valid_next;
    logic               found_reg;
    logic [COUNT_W-1:0] ocount_reg;
    logic [QCOLS_W-1:0] ocols_reg, ocols_next;

    logic [DEPTH_W-1:0] n_eff;
    logic [MAX_BOARD-1:0] conflict;
    logic               safe;
    logic [ROW_W-1:0]   prev_idx;
    logic [DEPTH_W-1:0] prev_inc;
    logic [DEPTH_W-1:0] depth_inc;
    logic               col_over;
    logic               step_hit;
    logic               step_fail;
    logic               place;

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = DEPTH_W'(1);
        end
        else if (DEPTH_W'(size_reg) > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = DEPTH_W'(size_reg);
        end
    end

    // one conflict lane per earlier row
    for (genvar i = 0; i < MAX_BOARD; i++)
    begin : g_lane
        logic [DEPTH_W-1:0] col_ext;
        logic [DEPTH_W-1:0] dc;
        logic [DEPTH_W-1:0] dr;
        assign col_ext     = DEPTH_W'(cols_reg[i]);
        assign dc          = (cur_reg > col_ext) ? (cur_reg - col_ext) : (col_ext - cur_reg);
        assign dr          = depth_reg - DEPTH_W'(i);
        assign conflict[i] = (DEPTH_W'(i) < depth_reg) && ((col_ext == cur_reg) || (dr == dc));
    end

    assign safe      = ~|conflict;
    assign prev_idx  = ROW_W'(depth_reg - DEPTH_W'(1));
    assign prev_inc  = DEPTH_W'(cols_reg[prev_idx]) + DEPTH_W'(1);
    assign depth_inc = depth_reg + DEPTH_W'(1);
    assign col_over  = (cur_reg >= n_eff);
    assign place     = !col_over && safe;
    assign step_hit  = place && (depth_inc == n_eff);
    assign step_fail = col_over && (depth_reg == '0);

    assign stat.exhausted = exh_reg;
    assign stat.full      = (depth_reg == n_eff);
    assign stat.hit       = step_hit;
    assign stat.fail      = step_fail;
    assign stat.out_free  = !valid_reg || m_tready;

    always_comb
    begin
        depth_next = depth_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        exh_next   = exh_reg;
        if (cfg_wr_en || cmd.clear)
        begin
            depth_next = '0;
            cur_next   = '0;
            count_next = '0;
            exh_next   = 1'b0;
        end
        else if (cmd.resume)
        begin
            depth_next = depth_reg - DEPTH_W'(1);
            cur_next   = prev_inc;
        end
        else if (cmd.step)
        begin
            if (col_over)
            begin
                if (depth_reg == '0)
                begin
                    exh_next = 1'b1;
                end
                else
                begin
                    depth_next = depth_reg - DEPTH_W'(1);
                    cur_next   = prev_inc;
                end
            end
            else if (safe)
            begin
                depth_next = depth_inc;
                if (step_hit)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
                else
                begin
                    cur_next = '0;
                end
            end
            else
            begin
                cur_next = cur_reg + DEPTH_W'(1);
            end
        end
    end

    always_comb
    begin
        ocols_next = '0;
        for (int r = 0; r < MAX_BOARD; r++)
        begin
            if (!exh_reg && (DEPTH_W'(r) < n_eff))
            begin
                ocols_next[r*COL_W +: COL_W] = cols_reg[r];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load_out)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= BOARD_RESET;
            depth_reg <= '0;
            cur_reg   <= '0;
            count_reg <= '0;
            exh_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            depth_reg <= depth_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            exh_reg   <= exh_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && place)
        begin
            cols_reg[ROW_W'(depth_reg)] <= cur_reg[COL_W-1:0];
        end
        if (cmd.load_out)
        begin
            found_reg  <= !exh_reg;
            ocount_reg <= count_reg;
            ocols_reg  <= ocols_next;
        end
    end

    assign m_tvalid  = valid_reg;
    assign out_found = found_reg;
    assign out_count = ocount_reg;
    assign out_cols  = ocols_reg;

    a_depth_in_board: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= n_eff)
        else $error("search depth beyond board");

    a_col_in_board: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= n_eff)
        else $error("candidate column beyond board");

    a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && step_hit && !cfg_wr_en) |=> (depth_reg == n_eff))
        else $error("solution without full placement");

    a_exh_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (exh_reg && !cmd.clear && !cfg_wr_en) |=> exh_reg)
        else $error("exhausted flag dropped without restart");

endmodule
